// ===== hw/rtl/mgsa_pkg.sv =====
// Package for the max-gap seat allocator.
// Holds result codes, operation codes, cell commands and configuration constants.
// Has no dependencies; every other file of the block but mgsa_tree refers to it by scoped names.
package mgsa_pkg;

	// Fixed payload widths of the request and result items.
	localparam int SLOT_FIELD_BITS   = 16;
	localparam int STATUS_FIELD_BITS = 2;

	// Configuration port constants.
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam int SEAT_REG_BITS = 17;
	localparam logic [SEAT_REG_BITS-1:0] SEAT_COUNT_RESET = 17'd65536;
	localparam logic REG_SEAT_COUNT = 1'b0;

	typedef enum logic {
		OP_ALLOCATE = 1'b0,
		OP_RELEASE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_FIELD_BITS-1:0] {
		STATUS_ALLOCATED = 2'd0,
		STATUS_RELEASED  = 2'd1,
		STATUS_NO_SLOT   = 2'd2,
		STATUS_FREE_SLOT = 2'd3
	} status_t;

	// Command broadcast to every cell of the occupied list.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} cell_cmd_t;

endpackage

// ===== hw/rtl/mgsa_ifs.sv =====
// Valid/ready channel interfaces for the request and result items.
// Depends on mgsa_pkg for the payload widths.
interface mgsa_req_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [mgsa_pkg::SLOT_FIELD_BITS-1:0] release_slot;

	modport source (output valid, output op, output release_slot, input ready);
	modport sink (input valid, input op, input release_slot, output ready);
endinterface

interface mgsa_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [mgsa_pkg::SLOT_FIELD_BITS-1:0]   chosen_slot;
	logic [mgsa_pkg::STATUS_FIELD_BITS-1:0] status;

	modport source (output valid, output chosen_slot, output status, input ready);
	modport sink (input valid, input chosen_slot, input status, output ready);
endinterface

// ===== hw/rtl/mgsa_cell.sv =====
// One cell of the sorted occupied list: holds one slot and works out its gap candidate.
// Depends on mgsa_pkg for the cell command codes.
module mgsa_cell #(
	parameter int SLOT_BITS = 16,
	parameter int CNT_BITS  = 7,
	parameter int INDEX     = 0
) (
	input  logic                 clk,
	input  mgsa_pkg::cell_cmd_t  cmd,
	input  logic [SLOT_BITS-1:0] key,
	input  logic [CNT_BITS-1:0]  count,
	input  logic [SLOT_BITS-1:0] left_entry,
	input  logic                 left_ge,
	input  logic [SLOT_BITS-1:0] right_entry,
	output logic [SLOT_BITS-1:0] entry,
	output logic                 ge,
	output logic                 match,
	output logic [SLOT_BITS-1:0] cand_dist,
	output logic [SLOT_BITS-1:0] cand_pick,
	output logic [SLOT_BITS-1:0] tail
);

	logic [SLOT_BITS-1:0] entry_q;
	logic                 valid;
	logic                 is_last;
	logic [SLOT_BITS-1:0] half;

	assign entry   = entry_q;
	assign valid   = count > CNT_BITS'(INDEX);
	assign is_last = count == CNT_BITS'(INDEX + 1);
	assign ge      = !valid || (entry_q >= key);
	assign match   = valid && (entry_q == key);
	assign tail    = is_last ? entry_q : '0;
	assign half    = (entry_q - left_entry) >> 1;

	// The first cell offers the left end of the row; the others offer the
	// midpoint of the gap to their left neighbor.
	always_comb begin
		if (!valid) begin
			cand_dist = '0;
			cand_pick = '0;
		end else if (INDEX == 0) begin
			cand_dist = entry_q;
			cand_pick = '0;
		end else begin
			cand_dist = half;
			cand_pick = left_entry + half;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			mgsa_pkg::CELL_INSERT: begin
				if (INDEX != 0 && left_ge) begin
					entry_q <= left_entry;
				end else if (ge) begin
					entry_q <= key;
				end
			end
			mgsa_pkg::CELL_REMOVE: begin
				if (ge) begin
					entry_q <= right_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

// ===== hw/rtl/mgsa_tree.sv =====
// Registered maximum tree over the cell candidates, lowest index winning ties.
// Also carries the last occupied slot to the root; no package dependencies.
module mgsa_tree #(
	parameter int LEAVES    = 64,
	parameter int SLOT_BITS = 16
) (
	input  logic                             clk,
	input  logic [LEAVES-1:0][SLOT_BITS-1:0] cand_dist,
	input  logic [LEAVES-1:0][SLOT_BITS-1:0] cand_pick,
	input  logic [LEAVES-1:0][SLOT_BITS-1:0] tail,
	output logic [SLOT_BITS-1:0]             root_dist,
	output logic [SLOT_BITS-1:0]             root_pick,
	output logic [SLOT_BITS-1:0]             root_tail
);

	function automatic int LEVELS_ARG(input int n);
		return (n < 2) ? 2 : n;
	endfunction

	localparam int LEVELS = $clog2(LEVELS_ARG(LEAVES));
	localparam int PAD    = 1 << LEVELS;
	localparam int NODES  = 2 * PAD - 1;

	logic [SLOT_BITS-1:0] dist_q [NODES];
	logic [SLOT_BITS-1:0] pick_q [NODES];
	logic [SLOT_BITS-1:0] tail_q [NODES];

	assign root_dist = dist_q[0];
	assign root_pick = pick_q[0];
	assign root_tail = tail_q[0];

	for (genvar k = 0; k < PAD; k++) begin : g_leaf
		if (k < LEAVES) begin : g_real
			always_ff @(posedge clk) begin
				dist_q[PAD-1+k] <= cand_dist[k];
				pick_q[PAD-1+k] <= cand_pick[k];
				tail_q[PAD-1+k] <= tail[k];
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				dist_q[PAD-1+k] <= '0;
				pick_q[PAD-1+k] <= '0;
				tail_q[PAD-1+k] <= '0;
			end
		end
	end

	// The right child wins only with a strictly larger distance.
	for (genvar i = 0; i < PAD - 1; i++) begin : g_node
		always_ff @(posedge clk) begin
			if (dist_q[2*i+2] > dist_q[2*i+1]) begin
				dist_q[i] <= dist_q[2*i+2];
				pick_q[i] <= pick_q[2*i+2];
			end else begin
				dist_q[i] <= dist_q[2*i+1];
				pick_q[i] <= pick_q[2*i+1];
			end
			tail_q[i] <= tail_q[2*i+1] | tail_q[2*i+2];
		end
	end

endmodule

// ===== hw/rtl/max_gap_seat_allocator.sv =====
// Max-gap seat allocator: top level with the cell chain, compare tree, sequencer and APB port.
// Depends on mgsa_pkg, mgsa_ifs (channel interfaces), mgsa_cell and mgsa_tree.
//
// The block keeps the occupied slots of a row in a sorted chain of CAPACITY cells, one
// slot per cell. An allocate item takes the free slot farthest from any occupied one
// (left end, gap midpoints, right end; ties to the lowest slot); a release item removes a
// slot, and releasing a free slot is answered with the free-slot status and changes
// nothing. Every cell works out its own gap candidate against its left neighbor, and a
// registered maximum tree of ceil(log2(CAPACITY)) levels picks the winner. An allocate
// item then waits for the root of that tree to settle and passes a decide state and a
// commit state before the block can accept again; a release item goes straight to its
// commit state, since the cells compare the slot in parallel. The block takes one item
// at a time; the result sits in an output register, so a new item is accepted while the
// previous result waits, and a commit waits only if that register is still full. The
// seat_count register (byte address 0) is to be written by the user through the APB port
// only while the block is idle, which the block itself does not enforce; values of 0
// act as 1 and values above 2**SLOT_BITS act as 2**SLOT_BITS.
module max_gap_seat_allocator #(
	parameter int CAPACITY  = 64,
	parameter int SLOT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mgsa_req_if.sink                            req,
	mgsa_rsp_if.source                          rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mgsa_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [mgsa_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [mgsa_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready
);

	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	localparam int TREE_LAT  = $clog2(CAPACITY);
	localparam int WAIT_BITS = $clog2(TREE_LAT + 1);
	// Wide enough for both the seat register and 2**SLOT_BITS.
	localparam int CW = (SLOT_BITS + 1 > mgsa_pkg::SEAT_REG_BITS) ?
		SLOT_BITS + 1 : mgsa_pkg::SEAT_REG_BITS;
	localparam logic [CW-1:0] MAXN = CW'(1) << SLOT_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_INS,
		ST_REL
	} state_t;

	// Last usable slot for a given seat count, with the register clamped to its range.
	function automatic logic [SLOT_BITS-1:0] seat_last(
		input logic [mgsa_pkg::SEAT_REG_BITS-1:0] sc
	);
		logic [CW-1:0] n;
		n = CW'(sc);
		if (n == '0) begin
			n = CW'(1);
		end
		if (n > MAXN) begin
			n = MAXN;
		end
		return SLOT_BITS'(n - CW'(1));
	endfunction

	state_t                                    state_q;
	logic [CNT_BITS-1:0]                       count_q;
	logic [SLOT_BITS-1:0]                      key_q;
	logic                                      ok_q;
	logic [WAIT_BITS-1:0]                      wait_q;
	logic                                      rsp_valid_q;
	logic [mgsa_pkg::SLOT_FIELD_BITS-1:0]      rsp_slot_q;
	mgsa_pkg::status_t                         rsp_status_q;
	logic [mgsa_pkg::SEAT_REG_BITS-1:0]        seat_count_q;
	logic [SLOT_BITS-1:0]                      last_q;

	mgsa_pkg::cell_cmd_t                       cell_cmd;
	logic [CAPACITY-1:0][SLOT_BITS-1:0]        entry;
	logic [CAPACITY-1:0][SLOT_BITS-1:0]        cand_dist;
	logic [CAPACITY-1:0][SLOT_BITS-1:0]        cand_pick;
	logic [CAPACITY-1:0][SLOT_BITS-1:0]        tail;
	logic [CAPACITY-1:0]                       ge;
	logic [CAPACITY-1:0]                       match;
	logic [SLOT_BITS-1:0]                      root_dist;
	logic [SLOT_BITS-1:0]                      root_pick;
	logic [SLOT_BITS-1:0]                      root_tail;

	logic                                      out_free;
	logic                                      found;
	logic                                      right_wins;
	logic [SLOT_BITS-1:0]                      right_dist;
	logic [SLOT_BITS-1:0]                      best_dist;
	logic [SLOT_BITS-1:0]                      best_pick;
	logic                                      cfg_write;

	// ---------------------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; pready is always high.
	// ---------------------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == mgsa_pkg::REG_SEAT_COUNT) ?
		mgsa_pkg::APB_DATA_BITS'(seat_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seat_count_q <= mgsa_pkg::SEAT_COUNT_RESET;
			last_q       <= seat_last(mgsa_pkg::SEAT_COUNT_RESET);
		end else if (cfg_write && paddr[2] == mgsa_pkg::REG_SEAT_COUNT) begin
			seat_count_q <= pwdata[mgsa_pkg::SEAT_REG_BITS-1:0];
			last_q       <= seat_last(pwdata[mgsa_pkg::SEAT_REG_BITS-1:0]);
		end
	end

	// ---------------------------------------------------------------------------------
	// Cell chain. Each cell sees its left neighbor for the gap and for insertion
	// shifts, and its right neighbor for removal shifts.
	// ---------------------------------------------------------------------------------
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [SLOT_BITS-1:0] left_entry;
		logic                 left_ge;
		logic [SLOT_BITS-1:0] right_entry;

		if (k == 0) begin : g_first
			assign left_entry = '0;
			assign left_ge    = 1'b0;
		end else begin : g_inner
			assign left_entry = entry[k-1];
			assign left_ge    = ge[k-1];
		end

		if (k == CAPACITY - 1) begin : g_end
			assign right_entry = '0;
		end else begin : g_mid
			assign right_entry = entry[k+1];
		end

		mgsa_cell #(
			.SLOT_BITS (SLOT_BITS),
			.CNT_BITS  (CNT_BITS),
			.INDEX     (k)
		) u_cell (
			.clk         (clk),
			.cmd         (cell_cmd),
			.key         (key_q),
			.count       (count_q),
			.left_entry  (left_entry),
			.left_ge     (left_ge),
			.right_entry (right_entry),
			.entry       (entry[k]),
			.ge          (ge[k]),
			.match       (match[k]),
			.cand_dist   (cand_dist[k]),
			.cand_pick   (cand_pick[k]),
			.tail        (tail[k])
		);
	end

	mgsa_tree #(
		.LEAVES    (CAPACITY),
		.SLOT_BITS (SLOT_BITS)
	) u_tree (
		.clk       (clk),
		.cand_dist (cand_dist),
		.cand_pick (cand_pick),
		.tail      (tail),
		.root_dist (root_dist),
		.root_pick (root_pick),
		.root_tail (root_tail)
	);

	// ---------------------------------------------------------------------------------
	// Decision. The right end is a candidate only when the last occupied slot lies
	// below the last usable slot, and it wins only with a strictly larger distance.
	// ---------------------------------------------------------------------------------
	assign found      = |match;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign right_dist = last_q - root_tail;
	assign right_wins = (last_q > root_tail) && (right_dist > root_dist);
	assign best_dist  = right_wins ? right_dist : root_dist;
	assign best_pick  = right_wins ? last_q : root_pick;

	always_comb begin
		cell_cmd = mgsa_pkg::CELL_HOLD;
		if (out_free) begin
			if (state_q == ST_INS && ok_q) begin
				cell_cmd = mgsa_pkg::CELL_INSERT;
			end else if (state_q == ST_REL && found) begin
				cell_cmd = mgsa_pkg::CELL_REMOVE;
			end
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.chosen_slot = rsp_slot_q;
	assign rsp.status      = rsp_status_q;

	// ---------------------------------------------------------------------------------
	// Sequencer with the list count and the result register.
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			key_q        <= '0;
			ok_q         <= 1'b0;
			wait_q       <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_slot_q   <= '0;
			rsp_status_q <= mgsa_pkg::STATUS_ALLOCATED;
		end else begin
			// A taken result empties the register unless a commit refills it in
			// the same cycle.
			if (rsp_valid_q && rsp.ready && state_q != ST_INS && state_q != ST_REL) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						key_q  <= SLOT_BITS'(req.release_slot);
						wait_q <= WAIT_BITS'(TREE_LAT - 1);
						if (req.op == mgsa_pkg::OP_RELEASE) begin
							state_q <= ST_REL;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// The tree was filled from a list that has not changed since the
					// last commit; wait for its root to settle.
					if (wait_q == '0) begin
						state_q <= ST_PICK;
					end else begin
						wait_q <= wait_q - WAIT_BITS'(1);
					end
				end
				ST_PICK: begin
					state_q <= ST_INS;
					if (count_q == '0) begin
						key_q <= '0;
						ok_q  <= 1'b1;
					end else if (count_q == CNT_BITS'(CAPACITY)) begin
						key_q <= best_pick;
						ok_q  <= 1'b0;
					end else begin
						key_q <= best_pick;
						ok_q  <= (best_dist != '0) && (best_pick <= last_q);
					end
				end
				ST_INS: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
						if (ok_q) begin
							count_q      <= count_q + CNT_BITS'(1);
							rsp_slot_q   <= mgsa_pkg::SLOT_FIELD_BITS'(key_q);
							rsp_status_q <= mgsa_pkg::STATUS_ALLOCATED;
						end else begin
							rsp_slot_q   <= '0;
							rsp_status_q <= mgsa_pkg::STATUS_NO_SLOT;
						end
					end
				end
				ST_REL: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
						rsp_slot_q  <= mgsa_pkg::SLOT_FIELD_BITS'(key_q);
						if (found) begin
							count_q      <= count_q - CNT_BITS'(1);
							rsp_status_q <= mgsa_pkg::STATUS_RELEASED;
						end else begin
							rsp_status_q <= mgsa_pkg::STATUS_FREE_SLOT;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/mgsa_checker.sv =====
// Port-level checks for the max-gap seat allocator, bound to its top level.
// Depends on mgsa_pkg for status codes and configuration constants.
module mgsa_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  req_valid,
	input logic                                  req_ready,
	input logic                                  rsp_valid,
	input logic                                  rsp_ready,
	input logic [mgsa_pkg::SLOT_FIELD_BITS-1:0]   chosen_slot,
	input logic [mgsa_pkg::STATUS_FIELD_BITS-1:0] status,
	input logic                                  psel,
	input logic                                  penable,
	input logic                                  pwrite,
	input logic [mgsa_pkg::APB_ADDR_BITS-1:0]     paddr,
	input logic [mgsa_pkg::APB_DATA_BITS-1:0]     pwdata,
	input logic [mgsa_pkg::APB_DATA_BITS-1:0]     prdata
);

	// A result that is not taken stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(chosen_slot) && $stable(status))
		else $error("result changed while stalled");

	// A refused allocation never reports a slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == mgsa_pkg::STATUS_NO_SLOT |-> chosen_slot == '0)
		else $error("no-slot result carries a slot number");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item accepted while busy");

	// A written seat count reads back in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2] == mgsa_pkg::REG_SEAT_COUNT |=>
		(!psel || pwrite || paddr[2] != mgsa_pkg::REG_SEAT_COUNT ||
		prdata == mgsa_pkg::APB_DATA_BITS'($past(pwdata[mgsa_pkg::SEAT_REG_BITS-1:0]))))
		else $error("seat count readback mismatch");

endmodule

bind max_gap_seat_allocator mgsa_checker u_mgsa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.chosen_slot (rsp.chosen_slot),
	.status      (rsp.status),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata)
);

// ===== tb/sv/seat_result_checker.sv =====
// Result checker for the max-gap seat allocator testbench.
// Watches the request, result and APB channels, predicts each result and compares it.
// Depends on mgsa_pkg and on the channel interfaces of mgsa_ifs.
`timescale 1ns / 1ps
module seat_result_checker #(
	parameter int CAPACITY  = 64,
	parameter int SLOT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	mgsa_req_if                                req,
	mgsa_rsp_if                                rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic                               pready,
	input  logic [mgsa_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [mgsa_pkg::APB_DATA_BITS-1:0] pwdata,
	output int unsigned                        mismatches,
	output int unsigned                        outstanding,
	output int unsigned                        granted,
	output int unsigned                        freed,
	output int unsigned                        stray_releases,
	output int unsigned                        list_full_hits,
	output int unsigned                        row_full_hits,
	output int unsigned                        shrunk_row_hits
);

	localparam logic [mgsa_pkg::APB_ADDR_BITS-1:0] SEAT_COUNT_ADDR =
		mgsa_pkg::APB_ADDR_BITS'(4 * int'(mgsa_pkg::REG_SEAT_COUNT));

	typedef struct packed {
		logic [mgsa_pkg::SLOT_FIELD_BITS-1:0] slot;
		mgsa_pkg::status_t                    status;
	} seat_result_t;

	logic [mgsa_pkg::SEAT_REG_BITS-1:0] seat_count;
	longint                             occupied[$];
	seat_result_t                       awaited[$];
	int unsigned                        results_checked;

	task automatic report_mismatch(input string what);
		$display("ERROR: %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Register values outside 1..2**SLOT_BITS are clamped into that range.
	function automatic longint usable_seats();
		longint row_limit;
		row_limit = longint'(1) << SLOT_BITS;
		if (seat_count == '0) return 1;
		if (longint'(seat_count) > row_limit) return row_limit;
		return longint'(seat_count);
	endfunction

	function automatic seat_result_t grant_seat();
		seat_result_t res;
		longint       row_end;
		longint       prev;
		longint       half;
		longint       best;
		longint       pick;
		int           pos;
		res.slot   = '0;
		res.status = mgsa_pkg::STATUS_NO_SLOT;
		row_end    = usable_seats() - 1;
		if (occupied.size() >= CAPACITY) begin
			list_full_hits++;
			return res;
		end
		if (occupied.size() == 0) begin
			occupied.push_back(0);
			res.status = mgsa_pkg::STATUS_ALLOCATED;
			granted++;
			return res;
		end
		// Left end first, then gap midpoints, then the right end; only a
		// strictly larger distance displaces the earlier candidate.
		prev = occupied[0];
		best = prev;
		pick = 0;
		for (int k = 1; k < occupied.size(); k++) begin
			half = (occupied[k] - prev) / 2;
			if (half > best) begin
				best = half;
				pick = prev + half;
			end
			prev = occupied[k];
		end
		if (row_end - prev > best) begin
			best = row_end - prev;
			pick = row_end;
		end
		if (best <= 0) begin
			row_full_hits++;
			return res;
		end
		if (pick > row_end) begin
			shrunk_row_hits++;
			return res;
		end
		pos = 0;
		while (pos < occupied.size() && occupied[pos] < pick) pos++;
		occupied.insert(pos, pick);
		res.slot   = mgsa_pkg::SLOT_FIELD_BITS'(pick);
		res.status = mgsa_pkg::STATUS_ALLOCATED;
		granted++;
		return res;
	endfunction

	function automatic seat_result_t free_seat(
		input logic [mgsa_pkg::SLOT_FIELD_BITS-1:0] slot
	);
		seat_result_t res;
		longint       wanted;
		wanted     = longint'(slot) & ((longint'(1) << SLOT_BITS) - 1);
		res.slot   = mgsa_pkg::SLOT_FIELD_BITS'(wanted);
		res.status = mgsa_pkg::STATUS_FREE_SLOT;
		for (int k = 0; k < occupied.size(); k++) begin
			if (occupied[k] == wanted) begin
				occupied.delete(k);
				res.status = mgsa_pkg::STATUS_RELEASED;
				break;
			end
		end
		if (res.status == mgsa_pkg::STATUS_RELEASED) freed++;
		else stray_releases++;
		return res;
	endfunction

	task automatic check_result(input logic [mgsa_pkg::SLOT_FIELD_BITS-1:0] slot,
			input logic [mgsa_pkg::STATUS_FIELD_BITS-1:0] status);
		seat_result_t want;
		results_checked++;
		if (awaited.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with nothing awaited",
				results_checked));
			return;
		end
		want = awaited.pop_front();
		if (slot !== want.slot) begin
			report_mismatch($sformatf("result %0d: chosen_slot %0d, predicted %0d",
				results_checked, slot, want.slot));
		end
		if (status !== want.status) begin
			report_mismatch($sformatf("result %0d: status %0d, predicted %0d",
				results_checked, status, want.status));
		end
	endtask

	// Results are checked before the item of the same edge is predicted, since
	// an item accepted at an edge cannot be answered at that same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seat_count = mgsa_pkg::SEAT_COUNT_RESET;
			occupied.delete();
			awaited.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) check_result(rsp.chosen_slot, rsp.status);
			if (req.valid && req.ready) begin
				if (mgsa_pkg::op_t'(req.op) == mgsa_pkg::OP_ALLOCATE) begin
					awaited.push_back(grant_seat());
				end else begin
					awaited.push_back(free_seat(req.release_slot));
				end
			end
			if (psel && penable && pwrite && pready && paddr == SEAT_COUNT_ADDR) begin
				seat_count = pwdata[mgsa_pkg::SEAT_REG_BITS-1:0];
			end
			outstanding <= awaited.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the max-gap seat allocator testbench: clock, reset, stimulus and verdict.
// Depends on mgsa_pkg, mgsa_ifs, the block max_gap_seat_allocator and seat_result_checker.
`timescale 1ns / 1ps
module tb_top;

	localparam int CAPACITY      = 64;
	localparam int SLOT_BITS     = 16;
	localparam int IDLE_PERCENT  = 34;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASES        = 7;
	localparam logic [mgsa_pkg::APB_ADDR_BITS-1:0] SEAT_COUNT_ADDR =
		mgsa_pkg::APB_ADDR_BITS'(4 * int'(mgsa_pkg::REG_SEAT_COUNT));

	// One random phase runs under a single seat_count setting.
	typedef struct {
		logic [mgsa_pkg::SEAT_REG_BITS-1:0] seats;
		int                                 items;
		int                                 alloc_percent;
		bit                                 no_idle;
		bit                                 hold_off;
	} phase_plan_t;

	logic                               clk;
	logic                               arst_n;
	logic                               psel;
	logic                               penable;
	logic                               pwrite;
	logic [mgsa_pkg::APB_ADDR_BITS-1:0] paddr;
	logic [mgsa_pkg::APB_DATA_BITS-1:0] pwdata;
	logic [mgsa_pkg::APB_DATA_BITS-1:0] prdata;
	logic                               pready;

	mgsa_req_if req_ch();
	mgsa_rsp_if rsp_ch();

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned granted;
	int unsigned freed;
	int unsigned stray_releases;
	int unsigned list_full_hits;
	int unsigned row_full_hits;
	int unsigned shrunk_row_hits;

	// Stimulus shaping shared between the sender and the receiver.
	bit          steady;
	int unsigned hold_requests;
	int unsigned items_sent;
	int unsigned settings_written;
	int unsigned cycle_count;

	// Slots that came back allocated; releases mostly pick from the recent ones.
	logic [mgsa_pkg::SLOT_FIELD_BITS-1:0] granted_slots[$];

	max_gap_seat_allocator #(
		.CAPACITY (CAPACITY),
		.SLOT_BITS(SLOT_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	seat_result_checker #(
		.CAPACITY (CAPACITY),
		.SLOT_BITS(SLOT_BITS)
	) seat_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.granted        (granted),
		.freed          (freed),
		.stray_releases (stray_releases),
		.list_full_hits (list_full_hits),
		.row_full_hits  (row_full_hits),
		.shrunk_row_hits(shrunk_row_hits)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Watchdog: a correct run finishes far below this many cycles.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ERROR: cycle limit of %0d reached, %0d results still awaited",
				CYCLE_LIMIT, outstanding);
			$display("Mismatches found");
			$finish;
		end
	end

	// Remember allocated slots so that most releases hit an occupied slot. Only
	// the last 256 are kept; stale ones turn into releases of free slots.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready &&
				rsp_ch.status == mgsa_pkg::STATUS_ALLOCATED) begin
			granted_slots.push_back(rsp_ch.chosen_slot);
			if (granted_slots.size() > 256) void'(granted_slots.pop_front());
		end
	end

	// Result receiver. It stalls at random unless the current phase runs without
	// idling, and on request it holds ready low for a long stretch so that the
	// output register fills and the block stops taking new items.
	initial begin : receiver
		int unsigned hold_left;
		int unsigned holds_done;
		hold_left = 0;
		holds_done = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Offers one item and returns at the edge where it is accepted. Valid is only
	// lowered when a gap is taken, so back-to-back items keep it high.
	task automatic send_item(input mgsa_pkg::op_t op,
			input logic [mgsa_pkg::SLOT_FIELD_BITS-1:0] slot);
		if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.op           <= op;
		req_ch.release_slot <= slot;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// Stops offering and waits until every awaited result has been taken, which
	// leaves the block idle since every item yields exactly one result.
	task automatic wait_until_idle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// APB write: setup, then access until pready.
	task automatic write_seat_count(input logic [mgsa_pkg::SEAT_REG_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SEAT_COUNT_ADDR;
		pwdata  <= mgsa_pkg::APB_DATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_written++;
	endtask

	// One random item. Allocates carry a random, ignored slot field. Releases
	// mostly target a recently granted slot, sometimes any slot of the row and
	// sometimes any 16-bit value.
	task automatic random_item(input int alloc_percent, input int unsigned row_hint);
		int unsigned                          roll;
		int unsigned                          lo;
		logic [mgsa_pkg::SLOT_FIELD_BITS-1:0] slot;
		if ($urandom_range(0, 99) < alloc_percent) begin
			send_item(mgsa_pkg::OP_ALLOCATE, mgsa_pkg::SLOT_FIELD_BITS'($urandom));
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 70 && granted_slots.size() != 0) begin
				lo = (granted_slots.size() > 64) ? granted_slots.size() - 64 : 0;
				slot = granted_slots[$urandom_range(lo, granted_slots.size() - 1)];
			end else if (roll < 85) begin
				slot = mgsa_pkg::SLOT_FIELD_BITS'($urandom_range(0, row_hint));
			end else begin
				slot = mgsa_pkg::SLOT_FIELD_BITS'($urandom);
			end
			send_item(mgsa_pkg::OP_RELEASE, slot);
		end
	endtask

	initial begin : stimulus
		phase_plan_t plan[PHASES];
		plan[0] = '{17'd65536, 95, 90, 1'b0, 1'b1};
		plan[1] = '{17'd2, 40, 55, 1'b0, 1'b0};
		plan[2] = '{17'd1, 25, 50, 1'b0, 1'b0};
		plan[3] = '{17'd300, 80, 60, 1'b1, 1'b0};
		plan[4] = '{17'd65535, 80, 65, 1'b0, 1'b1};
		plan[5] = '{17'd17, 60, 55, 1'b0, 1'b0};
		plan[6] = '{17'd131071, 70, 70, 1'b0, 1'b0};

		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		req_ch.valid        <= 1'b0;
		req_ch.op           <= mgsa_pkg::OP_ALLOCATE;
		req_ch.release_slot <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A seat_count of zero acts as a one-slot row: the empty row still gets
		// slot 0, the next allocate finds the row full, then release that slot
		// and release it again while it is free.
		write_seat_count('0);
		send_item(mgsa_pkg::OP_ALLOCATE, '0);
		send_item(mgsa_pkg::OP_ALLOCATE, '1);
		send_item(mgsa_pkg::OP_RELEASE, '0);
		send_item(mgsa_pkg::OP_RELEASE, '0);
		wait_until_idle();

		// The largest register value clamps to the full 16-bit row. This exercises
		// both ends, a midpoint, the tie toward the lower slot and releases of
		// free slots with alternating bit patterns.
		write_seat_count('1);
		send_item(mgsa_pkg::OP_ALLOCATE, '0);
		send_item(mgsa_pkg::OP_ALLOCATE, '0);
		send_item(mgsa_pkg::OP_ALLOCATE, '0);
		send_item(mgsa_pkg::OP_RELEASE, 16'd32767);
		send_item(mgsa_pkg::OP_RELEASE, 16'd32767);
		send_item(mgsa_pkg::OP_RELEASE, 16'hAAAA);
		send_item(mgsa_pkg::OP_ALLOCATE, 16'h5555);
		send_item(mgsa_pkg::OP_RELEASE, 16'h5555);
		wait_until_idle();

		// Shrinking the row below the occupied slots makes the best midpoint fall
		// outside it. Then the row is emptied and filled until it is full.
		write_seat_count(17'd10);
		send_item(mgsa_pkg::OP_ALLOCATE, '0);
		send_item(mgsa_pkg::OP_RELEASE, 16'hFFFF);
		send_item(mgsa_pkg::OP_RELEASE, 16'd32767);
		send_item(mgsa_pkg::OP_RELEASE, 16'd0);
		repeat (11) send_item(mgsa_pkg::OP_ALLOCATE, mgsa_pkg::SLOT_FIELD_BITS'($urandom));

		// Random phases. The first one is allocate-heavy on a wide row so that
		// the list of occupied slots reaches its capacity; one phase runs with no
		// idling on either side, and two phases start with a long receiver hold.
		foreach (plan[p]) begin
			wait_until_idle();
			write_seat_count(plan[p].seats);
			steady <= plan[p].no_idle;
			if (plan[p].hold_off) hold_requests <= hold_requests + 1;
			repeat (plan[p].items) random_item(plan[p].alloc_percent, plan[p].seats);
		end

		wait_until_idle();
		steady <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Summary: %0d items over %0d seat_count settings; %0d granted, %0d freed,",
			items_sent, settings_written, granted, freed);
		$display({"Summary: %0d releases of free slots, refusals %0d list full, ",
			"%0d row full, %0d shrunken row."},
			stray_releases, list_full_hits, row_full_hits, shrunk_row_hits);
		if (mismatches == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
